// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define FPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants for the binary32 / binary16 converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // Conversion direction
  localparam logic FUNC_NARROW = 1'b0;
  localparam logic FUNC_WIDEN  = 1'b1;

  // Exponent landmarks (biased binary32 exponent unless noted)
  localparam logic [7:0] EXP_BIAS_DIFF  = 8'd112;  // 127 - 15
  localparam logic [7:0] NARROW_TINY    = 8'd102;  // below this flushes to zero
  localparam logic [7:0] NARROW_MAX_SUB = 8'd112;  // up to this is half-subnormal
  localparam logic [7:0] NARROW_OVF     = 8'd143;  // from this on is infinity
  localparam logic [7:0] SUB_SHIFT_BASE = 8'd126;  // 14 - rebased exponent
  localparam logic [7:0] WIDEN_SUB_EXP  = 8'd113;  // 1 - 15 + 127
  localparam logic [4:0] HALF_EXP_MAX   = 5'h1f;
  localparam logic [7:0] SINGLE_EXP_MAX = 8'hff;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_SUB  = 2'd1,
    CLS_NORM = 2'd2,
    CLS_INF  = 2'd3
  } cls_t;

  // Decode stage word
  typedef struct packed {
    logic        func;
    logic        sign;
    cls_t        cls;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [4:0]  shamt;
    logic        last;
  } s1_t;

  // Align stage word
  typedef struct packed {
    logic        func;
    logic        sign;
    cls_t        cls;
    logic [7:0]  expo;
    logic [10:0] frac;
    logic        last;
  } s2_t;

endpackage

`default_nettype wire

// ----- sv/fpc_in_if.sv -----
// ----------------------------------------------------------------------------
// fpc_in_if
// Source word channel: direction select, source bits and end-of-buffer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value_bits;
  logic        last_in;

  modport source (output valid, output func, output value_bits, output last_in,
                  input ready);
  modport sink   (input valid, input func, input value_bits, input last_in,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/fpc_out_if.sv -----
// ----------------------------------------------------------------------------
// fpc_out_if
// Result word channel: converted bits and end-of-buffer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        last_out;

  modport source (output valid, output result_bits, output last_out, input ready);
  modport sink   (input valid, input result_bits, input last_out, output ready);
endinterface

`default_nettype wire

// ----- sv/fpc_decode.sv -----
// ----------------------------------------------------------------------------
// fpc_decode
// Stage 1: split the source word, classify it and find the shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_decode import fpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire logic        up_func,
  input  wire logic [31:0] up_bits,
  input  wire logic        up_last,
  output logic             dn_valid,
  output s1_t              dn_data,
  input  wire logic        dn_ready
);

  logic       valid_r;
  s1_t        data_r;
  s1_t        data_nxt;
  logic [7:0] exp8;
  logic [7:0] sub_shift;
  logic [4:0] exp5;
  logic [9:0] m10;
  logic [3:0] msb;
  logic [3:0] shifts;

  always_comb begin
    exp8      = up_bits[30:23];
    sub_shift = SUB_SHIFT_BASE - exp8;
    exp5      = up_bits[14:10];
    m10       = up_bits[9:0];
    msb       = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m10[i]) msb = 4'(i);
    end
    shifts = 4'd10 - msb;

    data_nxt.func = up_func;
    data_nxt.last = up_last;
    if (up_func == FUNC_NARROW) begin
      data_nxt.sign  = up_bits[31];
      data_nxt.expo  = exp8;
      data_nxt.mant  = {1'b1, up_bits[22:0]};
      data_nxt.shamt = sub_shift[4:0];
      if (up_bits[30:0] == 31'd0 || exp8 < NARROW_TINY) begin
        data_nxt.cls = CLS_ZERO;
      end else if (exp8 <= NARROW_MAX_SUB) begin
        data_nxt.cls = CLS_SUB;
      end else if (exp8 >= NARROW_OVF) begin
        data_nxt.cls = CLS_INF;
      end else begin
        data_nxt.cls = CLS_NORM;
      end
    end else begin
      data_nxt.sign  = up_bits[15];
      data_nxt.expo  = {3'b000, exp5};
      data_nxt.mant  = {14'd0, m10};
      data_nxt.shamt = {1'b0, shifts};
      if (exp5 == 5'd0) begin
        data_nxt.cls = (m10 == 10'd0) ? CLS_ZERO : CLS_SUB;
      end else if (exp5 == HALF_EXP_MAX) begin
        data_nxt.cls = CLS_INF;
      end else begin
        data_nxt.cls = CLS_NORM;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fpc_align.sv -----
// ----------------------------------------------------------------------------
// fpc_align
// Stage 2: shift the significand and rebase the exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_align import fpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  output logic      up_ready,
  input  s1_t       up_data,
  output logic      dn_valid,
  output s2_t       dn_data,
  input  wire logic dn_ready
);

  logic        valid_r;
  s2_t         data_r;
  s2_t         data_nxt;
  logic [4:0]  nsh;
  logic [23:0] nq;
  logic [7:0]  ne8;
  logic [9:0]  ws;

  always_comb begin
    // keep the first dropped bit as frac[0] for rounding in the next stage
    nsh = up_data.shamt - 5'd1;
    nq  = up_data.mant >> nsh;
    ne8 = up_data.expo - EXP_BIAS_DIFF;
    ws  = up_data.mant[9:0] << up_data.shamt[3:0];

    data_nxt.func = up_data.func;
    data_nxt.sign = up_data.sign;
    data_nxt.cls  = up_data.cls;
    data_nxt.last = up_data.last;
    if (up_data.func == FUNC_NARROW) begin
      data_nxt.expo = {3'b000, ne8[4:0]};
      if (up_data.cls == CLS_SUB) begin
        data_nxt.frac = nq[10:0];
      end else begin
        data_nxt.frac = {1'b0, up_data.mant[22:13]};
      end
    end else begin
      if (up_data.cls == CLS_SUB) begin
        data_nxt.expo = WIDEN_SUB_EXP - {4'd0, up_data.shamt[3:0]};
        data_nxt.frac = {1'b0, ws};
      end else begin
        data_nxt.expo = up_data.expo + EXP_BIAS_DIFF;
        data_nxt.frac = {1'b0, up_data.mant[9:0]};
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fpc_pack.sv -----
// ----------------------------------------------------------------------------
// fpc_pack
// Stage 3: round half-subnormals, assemble the result word and hold it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_pack import fpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  s2_t        up_data,
  output logic       dn_valid,
  output logic [31:0] dn_bits,
  output logic       dn_last,
  input  wire logic  dn_ready
);

  logic        valid_r;
  logic [31:0] bits_r;
  logic [31:0] bits_nxt;
  logic        last_r;
  logic [10:0] rnd;

  always_comb begin
    // a carry out of the largest subnormal lands on the smallest normal
    rnd = {1'b0, up_data.frac[10:1]} + {10'd0, up_data.frac[0]};
    if (up_data.func == FUNC_NARROW) begin
      case (up_data.cls)
        CLS_ZERO: bits_nxt = {16'd0, up_data.sign, 15'd0};
        CLS_SUB:  bits_nxt = {16'd0, up_data.sign, 4'd0, rnd};
        CLS_NORM: bits_nxt = {16'd0, up_data.sign, up_data.expo[4:0], up_data.frac[9:0]};
        CLS_INF:  bits_nxt = {16'd0, up_data.sign, HALF_EXP_MAX, 10'd0};
        default:  bits_nxt = 32'd0;
      endcase
    end else begin
      case (up_data.cls)
        CLS_ZERO: bits_nxt = {up_data.sign, 31'd0};
        CLS_SUB,
        CLS_NORM: bits_nxt = {up_data.sign, up_data.expo, up_data.frac[9:0], 13'd0};
        CLS_INF:  bits_nxt = {up_data.sign, SINGLE_EXP_MAX, up_data.frac[9:0], 13'd0};
        default:  bits_nxt = 32'd0;
      endcase
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_bits  = bits_r;
  assign dn_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      bits_r <= bits_nxt;
      last_r <= up_data.last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fp32_fp16_format_converter_core.sv -----
// ----------------------------------------------------------------------------
// fp32_fp16_format_converter_core
// binary32 <-> binary16 converter, direction chosen per word.
// ----------------------------------------------------------------------------
// Three register stages (decode, align, pack) with valid bits traveling beside
// the data: a word moves from the decode register to the align register and
// then to the pack register, and one word can enter every cycle while the
// output side does not stall.
// Each stage takes a new word whenever it is empty or its own word moves on,
// so a stalled output fills the pipeline before in_ch.ready drops; ready is
// combinational from out_ch.ready through the three stages. Narrowing flushes
// tiny values and binary32 subnormals to signed zero, rounds half-subnormals
// half-up, truncates normals and turns overflow and NaN into signed infinity.
// Widening is exact and keeps NaN payloads. last_in rides along as last_out.
`default_nettype none

module fp32_fp16_format_converter_core import fpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fpc_in_if.sink    in_ch,
  fpc_out_if.source out_ch
);

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  fpc_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_func  (in_ch.func),
    .up_bits  (in_ch.value_bits),
    .up_last  (in_ch.last_in),
    .dn_valid (s1_valid),
    .dn_data  (s1_data),
    .dn_ready (s1_ready)
  );

  fpc_align u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_data  (s2_data),
    .dn_ready (s2_ready)
  );

  fpc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_ch.valid),
    .dn_bits  (out_ch.result_bits),
    .dn_last  (out_ch.last_out),
    .dn_ready (out_ch.ready)
  );

endmodule

`default_nettype wire

// ----- sv/fpc_checker.sv -----
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level checks on occupancy and flow control of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_bits,
  input wire logic        out_last
);

  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words in flight
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + 3'd1;
    if (!in_acc && out_acc) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `FPC_ASSERT_NOW(a_depth, clk, rst_n, 1'b1, cnt_r <= 3'd3, "more words in flight than stages")
  `FPC_ASSERT_NOW(a_no_phantom, clk, rst_n, out_valid, cnt_r != 3'd0, "result without a word")
  `FPC_ASSERT_NOW(a_flow, clk, rst_n, out_ready, in_ready, "input stalled with output open")
  `FPC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits) && $stable(out_last), "stalled result changed")

endmodule

bind fp32_fp16_format_converter_core fpc_checker u_fpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_bits  (out_ch.result_bits),
  .out_last  (out_ch.last_out)
);

`default_nettype wire
